### sv/mtwo_pkg.sv
// Package for the multi-table wavetable oscillator.
// Holds field widths, action and register codes, defaults and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package mtwo_pkg;

  // Field widths fixed by the item format
  localparam int ACTION_W   = 2;
  localparam int ADDR_W     = 12;
  localparam int SAMPLE_W   = 16;
  localparam int LEN_W      = 13;
  localparam int INC_W      = 32;
  localparam int NUMT_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int FRAC_W     = 16;

  // Defaults for the top level parameters
  localparam int SAMPLE_DEPTH_DEF = 4096;
  localparam int MAX_TABLES_DEF   = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_TABLES = 1'd1;

  // Item actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_WR_SAMPLE = 2'd0,
    ACT_WR_LEN    = 2'd1,
    ACT_TICK      = 2'd2
  } action_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr_sample;
    logic wr_len;
    logic tick_start;
    logic sel;
    logic sum;
    logic mul;
    logic rd0;
    logic rd1;
    logic prod;
    logic fin;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic sum_done;
    logic out_free;
  } stat_t;

endpackage

### sv/mtwo_ctrl.sv
// Controller state machine of the wavetable oscillator.
// Sequences one item at a time and issues datapath commands; uses mtwo_pkg.
`timescale 1ns / 1ps

module mtwo_ctrl
  import mtwo_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ACTION_W-1:0] action_i,
  input  stat_t               stat_i,
  output cmd_t                cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SEL  = 8'b0000_0010,
    ST_SUM  = 8'b0000_0100,
    ST_MUL  = 8'b0000_1000,
    ST_RD0  = 8'b0001_0000,
    ST_RD1  = 8'b0010_0000,
    ST_PROD = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // Items are taken only between ticks
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_e'(action_i))
            ACT_WR_SAMPLE: cmd_o.wr_sample = 1'b1;
            ACT_WR_LEN:    cmd_o.wr_len = 1'b1;
            ACT_TICK: begin
              cmd_o.tick_start = 1'b1;
              state_d = ST_SEL;
            end
            default: ;
          endcase
        end
      end
      ST_SEL: begin
        cmd_o.sel = 1'b1;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (stat_i.sum_done) begin
          state_d = ST_MUL;
        end else begin
          cmd_o.sum = 1'b1;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_RD0;
      end
      ST_RD0: begin
        cmd_o.rd0 = 1'b1;
        state_d = ST_RD1;
      end
      ST_RD1: begin
        cmd_o.rd1 = 1'b1;
        state_d = ST_PROD;
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register can take the result
        if (stat_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A tick leaves idle for table selection
  a_tick_to_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tick_start |=> state_q == ST_SEL)
    else $error("tick did not enter table selection");

  // The offset walk ends only at the selected table
  a_sum_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) && !stat_i.sum_done |=> state_q == ST_SUM)
    else $error("offset walk left early");

  // A finished result returns the block to idle
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |=> state_q == ST_IDLE && !in_stall_o)
    else $error("block not idle after result");

endmodule

### sv/mtwo_dp.sv
// Datapath of the wavetable oscillator: configuration, phase, table
// lengths, sample store, interpolation and output register. Uses mtwo_pkg.
`timescale 1ns / 1ps

module mtwo_dp
  import mtwo_pkg::*;
#(
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
  parameter int MAX_TABLES   = MAX_TABLES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [ADDR_W-1:0]          address_i,
  input  logic signed [SAMPLE_W-1:0] sample_value_i,
  input  logic [LEN_W-1:0]           table_length_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic signed [SAMPLE_W-1:0] sample_o,
  input  cmd_t                       cmd_i,
  output stat_t                      stat_o
);

  // Store address width (depth is a power of two, so wrap is a mask)
  localparam int AW  = $clog2(SAMPLE_DEPTH);
  localparam int TW  = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
  localparam int NW  = $clog2(MAX_TABLES + 1);
  localparam int CW  = (NW > NUMT_W) ? NW : NUMT_W;
  localparam int SW  = (AW > LEN_W) ? AW : LEN_W;
  localparam int WAW = (AW > ADDR_W) ? AW : ADDR_W;
  localparam int PW  = INC_W + NW;
  localparam int MW  = INC_W + LEN_W;
  localparam int DW  = SAMPLE_W + 1;
  localparam int XW  = 2 * DW;
  localparam int RW  = XW - FRAC_W;

  // Configuration registers
  logic [INC_W-1:0]  inc_q;
  logic [NUMT_W-1:0] numt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q  <= '0;
      numt_q <= NUMT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PHASE_INC:  inc_q <= cfg_data_i[INC_W-1:0];
        REG_NUM_TABLES: numt_q <= cfg_data_i[NUMT_W-1:0];
        default: ;
      endcase
    end
  end

  // Table lengths, all one after reset
  logic [LEN_W-1:0] lens_q [MAX_TABLES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TABLES; i++) begin
        lens_q[i] <= LEN_W'(1);
      end
    end else if (cmd_i.wr_len && (address_i < ADDR_W'(MAX_TABLES))) begin
      lens_q[address_i[TW-1:0]] <= table_length_i;
    end
  end

  // Effective table count and selection product
  logic [CW-1:0]   numt_ext;
  logic [NW-1:0]   n_d;
  logic [NW-1:0]   nm1;
  logic [PW-1:0]   sel_prod;
  logic [INC_W-1:0] phase_q;
  logic [NW-1:0]   n_q;
  logic [NW:0]     sel_q;

  always_comb begin
    numt_ext = CW'(numt_q);
    if (numt_ext == '0) begin
      n_d = NW'(1);
    end else if (numt_ext > CW'(MAX_TABLES)) begin
      n_d = NW'(MAX_TABLES);
    end else begin
      n_d = NW'(numt_ext);
    end
    nm1      = n_d - NW'(1);
    sel_prod = PW'(inc_q) * PW'(nm1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (cmd_i.tick_start) begin
      phase_q <= phase_q + inc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_start) begin
      n_q   <= n_d;
      sel_q <= sel_prod[PW-1:INC_W-1];
    end
  end

  // Table pick and offset walk, one table per cycle
  logic [TW-1:0]    t_q, k_q;
  logic [AW-1:0]    offset_q;
  logic [LEN_W-1:0] len_k, len_t;
  logic [SW-1:0]    len_k_ext;

  always_comb begin
    len_k     = (lens_q[k_q] == '0) ? LEN_W'(1) : lens_q[k_q];
    len_t     = (lens_q[t_q] == '0) ? LEN_W'(1) : lens_q[t_q];
    len_k_ext = SW'(len_k);
  end

  assign stat_o.sum_done = (k_q == t_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel) begin
      t_q      <= (sel_q >= (NW + 1)'(n_q)) ? TW'(n_q - NW'(1)) : TW'(sel_q);
      k_q      <= '0;
      offset_q <= '0;
    end else if (cmd_i.sum) begin
      k_q      <= k_q + TW'(1);
      offset_q <= offset_q + len_k_ext[AW-1:0];
    end
  end

  // Phase scaled by table length
  logic [MW-1:0]    p_q;
  logic [LEN_W-1:0] len_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p_q   <= MW'(phase_q) * MW'(len_t);
      len_q <= len_t;
    end
  end

  // Neighbor indexes and store addresses
  logic [LEN_W-1:0]  idx0;
  logic [LEN_W:0]    idx1_raw;
  logic [LEN_W-1:0]  idx1;
  logic [FRAC_W-1:0] frac;
  logic [SW-1:0]     idx0_ext, idx1_ext;
  logic [AW-1:0]     raddr;
  logic [WAW-1:0]    waddr_ext;

  always_comb begin
    idx0      = p_q[MW-1:INC_W];
    frac      = p_q[INC_W-1:INC_W-FRAC_W];
    idx1_raw  = {1'b0, idx0} + (LEN_W + 1)'(1);
    idx1      = (idx1_raw >= {1'b0, len_q}) ? '0 : idx1_raw[LEN_W-1:0];
    idx0_ext  = SW'(idx0);
    idx1_ext  = SW'(idx1);
    raddr     = cmd_i.rd0 ? (offset_q + idx0_ext[AW-1:0])
                          : (offset_q + idx1_ext[AW-1:0]);
    waddr_ext = WAW'(address_i);
  end

  // Sample store, registered read
  logic [SAMPLE_W-1:0] mem_q [SAMPLE_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_sample) begin
      mem_q[waddr_ext[AW-1:0]] <= sample_value_i;
    end
    if (cmd_i.rd0 || cmd_i.rd1) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Interpolation: s0 + floor(frac * (s1 - s0) / 2^16)
  logic signed [SAMPLE_W-1:0] s0_q;
  logic signed [DW-1:0]       diff;
  logic signed [XW-1:0]       prod_q;
  logic signed [RW-1:0]       res;

  assign diff = DW'($signed(rdata_q)) - DW'(s0_q);
  assign res  = RW'(s0_q) + prod_q[XW-1:FRAC_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd1) begin
      s0_q <= $signed(rdata_q);
    end
    if (cmd_i.prod) begin
      prod_q <= $signed({1'b0, frac}) * diff;
    end
  end

  // Output register
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q;

  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign sample_o        = sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      sample_q <= res[SAMPLE_W-1:0];
    end
  end

  // The offset walk never passes the selected table
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sum |-> k_q < t_q)
    else $error("offset walk past selected table");

  // Selected table is within the effective count
  a_table_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sel |=> {1'b0, t_q} < (TW + 1)'(n_q))
    else $error("selected table out of range");

  // Scaled length is never zero
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul |=> len_q != '0)
    else $error("zero table length used");

endmodule

### sv/multi_table_wavetable_oscillator.sv
// Top level of the multi-table wavetable oscillator.
// Joins mtwo_ctrl (sequencer) and mtwo_dp (datapath); uses mtwo_pkg.
//
//   channel   handshake                 fields
//   input     in_valid_i / in_stall_o   action_i address_i sample_value_i table_length_i
//   output    out_valid_o / out_stall_i sample_o
//   config    cfg_we_i                  cfg_idx_i cfg_data_i
//
// Sample and length writes are taken while idle and do not stall the input. A tick
// steps through table selection, an offset walk over the lengths of the tables
// below the selected table t, one table per cycle, and a done step, then the
// phase multiply, two store reads, the interpolation multiply and the output
// load; the next item is taken once the block is back in idle. Reset clears
// phase and phase increment and sets the table count and every table length to
// one; the sample store is not cleared. A stalled result holds the next tick at
// its last step; no items, writes included, are taken meanwhile.
`timescale 1ns / 1ps

module multi_table_wavetable_oscillator
  import mtwo_pkg::*;
#(
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
  parameter int MAX_TABLES   = MAX_TABLES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ACTION_W-1:0]        action_i,
  input  logic [ADDR_W-1:0]          address_i,
  input  logic signed [SAMPLE_W-1:0] sample_value_i,
  input  logic [LEN_W-1:0]           table_length_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_o
);

  cmd_t  cmd;
  stat_t stat;

  mtwo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mtwo_dp #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .MAX_TABLES   (MAX_TABLES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .address_i      (address_i),
    .sample_value_i (sample_value_i),
    .table_length_i (table_length_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .sample_o       (sample_o),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule
